>>> rtl/voxel_box_occupancy_scan_defines.svh
// ----------------------------------------------------------------------------
// voxel box occupancy scan: assertion macros
// shared property wrappers clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef VOXEL_BOX_OCCUPANCY_SCAN_DEFINES_SVH
`define VOXEL_BOX_OCCUPANCY_SCAN_DEFINES_SVH

// property must hold at every clock edge out of reset
`define VBOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen out of reset
`define VBOS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> rtl/voxbox_pkg.sv
// ----------------------------------------------------------------------------
// voxbox_pkg
// shared constants and codes of the voxel box occupancy scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package voxbox_pkg;

  localparam int unsigned CoordW       = 26;
  localparam int unsigned WordsPerSlot = 768;
  localparam int unsigned InDataW      = 40;
  localparam int unsigned OutDataW     = 96;

  typedef enum logic [1:0] {
    OP_WRITE_WORD = 2'd0,
    OP_SET_SLOT   = 2'd1,
    OP_START      = 2'd2,
    OP_PAGE       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_LIMIT = 2'd1,
    ST_TOO_MANY   = 2'd2
  } status_e;

  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

endpackage

>>> rtl/voxbox_ram.sv
// ----------------------------------------------------------------------------
// voxbox_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxbox_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/voxbox_mac.sv
// ----------------------------------------------------------------------------
// voxbox_mac
// shared registered multiply-add used for box sizing and section numbering
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxbox_mac #(
  parameter int unsigned W = 8
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  input  logic [W-1:0]   c_i,
  output logic [2*W:0]   p_o
);

  logic [2*W:0] p_q;
  logic [2*W:0] p_d;

  assign p_d = (2*W+1)'(a_i) * (2*W+1)'(b_i) + (2*W+1)'(c_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

>>> rtl/voxel_box_occupancy_scan.sv
// ----------------------------------------------------------------------------
// voxel_box_occupancy_scan
// Operations arrive on the slave stream: tuser carries the operation code,
// tdata the slot, word index, mask word, presence flag and page limit.
// Mask words, presence and scan start give no output.
// A page request sizes the box on the shared multiply-add (a check,
// then states MUL1 to MUL3), then walks rows of 16-column segments: a
// segment with a present slot takes two multiply-add steps for the
// section number and two reads of the mask ram, then emits its hit
// records; an absent slot is skipped after the section number. The
// closing item (tlast high) carries count, done flag and status; a zero
// limit answers with a closing item in the cycle after the transaction.
// Results leave through one output register; when the receiver holds
// tready low the sequencer waits on that register and accepts no input.
// One operation is worked on at a time; tready is high only when idle.
// Reset clears the box to zero, the cursor to zero, all slot presence
// bits and marks the scan over; the mask ram is not cleared.
// Configuration registers are written through cfg_we_i / cfg_idx_i.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voxel_box_occupancy_scan_defines.svh"

module voxel_box_occupancy_scan #(
  parameter int unsigned MAX_SLOTS = 64,
  parameter int unsigned MAX_PAGE  = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [25:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // section_slot[5:0], word_index[15:6], word_value[31:16],
  // slot_present[32], page_limit[38:33], zero fill above
  input  logic [39:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // hit_x[25:0], hit_y[51:26], hit_z[77:52], slot_index[83:78],
  // records_given[89:84], scan_finished[90], status[92:91], zero fill above
  output logic [95:0] m_axis_tdata_o,
  // kind[0]
  output logic [0:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned MW = $clog2(MAX_SLOTS + 2);
  localparam int unsigned VN = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
  localparam int unsigned VW = (VN > 1) ? $clog2(VN) : 1;
  localparam int unsigned RamDepth = MAX_SLOTS * voxbox_pkg::WordsPerSlot;
  localparam int unsigned AW = $clog2(RamDepth);
  localparam int unsigned PW = 2 * MW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_MUL3 = 4'd4;
  localparam logic [3:0] S_HEAD = 4'd5;
  localparam logic [3:0] S_SEC1 = 4'd6;
  localparam logic [3:0] S_SEC2 = 4'd7;
  localparam logic [3:0] S_RD1  = 4'd8;
  localparam logic [3:0] S_RD2  = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;
  localparam logic [3:0] S_CLOSE = 4'd11;

  localparam logic [25:0] Bias = 26'h2000000;

  logic [3:0]  state_q, state_d;
  logic [25:0] bminx_q, bminy_q, bminz_q, bmaxx_q, bmaxy_q, bmaxz_q;
  logic [26:0] cx_q, cx_d;
  logic [25:0] cy_q, cy_d, cz_q, cz_d;
  logic        over_q, over_d;
  logic [VN-1:0] valid_q, valid_d;
  logic [5:0]  lim_q, lim_d, cnt_q, cnt_d;
  logic [1:0]  stat_q, stat_d;
  logic [MW-1:0] wc_q, wc_d, hc_q, hc_d, dc_q, dc_d, sec_q, sec_d;
  logic [25:0] end_q, end_d;
  logic [21:0] xb_q, xb_d;
  logic [1:0]  edges_q, edges_d;
  logic [15:0] mraw_q, mraw_d, mask_q, mask_d;

  logic        ov_q, ov_d;
  logic        okind_q, okind_d, olast_q, olast_d, ofin_q, ofin_d;
  logic [25:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [5:0]  oslot_q, oslot_d, ocnt_q, ocnt_d;
  logic [1:0]  ostat_q, ostat_d;

  logic        out_free, acc;
  logic [1:0]  in_op;
  logic [5:0]  in_slot, in_limit, lim_sat;
  logic [9:0]  in_widx;
  logic [15:0] in_word;
  logic        in_pres;

  logic [MW-1:0] mac_a, mac_b, mac_c;
  logic [PW-1:0] mac_p;

  logic [22:0] wspan, hspan, dspan;
  logic [MW-1:0] wclip, hclip, dclip;
  logic        inverted;
  logic [21:0] xs_full, ys_full, zs_full;
  logic [25:0] xend, endv;
  logic [1:0]  edges;
  logic [9:0]  row3;
  logic [MW-1:0] sec_sel;
  logic [31:0] base32;
  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] waddr32;
  logic [15:0] ram_q;
  logic [15:0] alt, bnd, lo_m, hi_m;
  logic [3:0]  nbit;
  logic [25:0] sel;
  logic        sec_ok;

  assign in_op    = s_axis_tuser_i;
  assign in_slot  = s_axis_tdata_i[5:0];
  assign in_widx  = s_axis_tdata_i[15:6];
  assign in_word  = s_axis_tdata_i[31:16];
  assign in_pres  = s_axis_tdata_i[32];
  assign in_limit = s_axis_tdata_i[38:33];
  assign lim_sat  = (32'(in_limit) > MAX_PAGE) ? 6'(MAX_PAGE) : in_limit;

  assign out_free        = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  // box extent in sections, clipped just above the slot count
  assign wspan = {1'b0, bmaxx_q[25:4]} - {1'b0, bminx_q[25:4]} + 23'd1;
  assign hspan = {1'b0, bmaxy_q[25:4]} - {1'b0, bminy_q[25:4]} + 23'd1;
  assign dspan = {1'b0, bmaxz_q[25:4]} - {1'b0, bminz_q[25:4]} + 23'd1;
  assign wclip = (wspan > 23'(MAX_SLOTS)) ? MW'(MAX_SLOTS + 1) : wspan[MW-1:0];
  assign hclip = (hspan > 23'(MAX_SLOTS)) ? MW'(MAX_SLOTS + 1) : hspan[MW-1:0];
  assign dclip = (dspan > 23'(MAX_SLOTS)) ? MW'(MAX_SLOTS + 1) : dspan[MW-1:0];

  assign inverted = (bmaxx_q < bminx_q) || (bmaxy_q < bminy_q) ||
                    (bmaxz_q < bminz_q) || (cy_q < bminy_q) || (cy_q > bmaxy_q) ||
                    (cz_q < bminz_q) || (cz_q > bmaxz_q) || (cx_q < {1'b0, bminx_q});

  assign xs_full = cx_q[25:4] - bminx_q[25:4];
  assign ys_full = cy_q[25:4] - bminy_q[25:4];
  assign zs_full = cz_q[25:4] - bminz_q[25:4];

  assign xend  = {cx_q[25:4], 4'hf};
  assign endv  = (bmaxx_q < xend) ? bmaxx_q : xend;
  assign edges = {1'b0, (cy_q == bminy_q) || (cy_q == bmaxy_q)} +
                 {1'b0, (cz_q == bminz_q) || (cz_q == bmaxz_q)};
  assign row3  = {1'b0, cy_q[3:0], cz_q[3:0], 1'b0} + {2'b00, cy_q[3:0], cz_q[3:0]};

  assign sec_sel = (state_q == S_SEC2) ? mac_p[MW-1:0] : sec_q;
  assign base32  = (32'(sec_sel) << 9) + (32'(sec_sel) << 8) + 32'(row3);
  assign sec_ok  = (mac_p < PW'(VN)) && valid_q[mac_p[VW-1:0]];

  always_comb begin
    if (state_q == S_SEC2) begin
      ram_raddr = AW'(base32 + 32'(edges));
    end else begin
      ram_raddr = AW'(base32 + 32'(edges_q) + 32'd1);
    end
  end

  assign waddr32   = (32'(in_slot) << 9) + (32'(in_slot) << 8) + 32'(in_widx);
  assign ram_waddr = waddr32[AW-1:0];
  assign ram_we    = acc && (in_op == voxbox_pkg::OP_WRITE_WORD) &&
                     (32'(in_slot) < MAX_SLOTS) && (in_widx < 10'(voxbox_pkg::WordsPerSlot));

  voxbox_ram #(
    .Width (16),
    .Depth (RamDepth)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_word),
    .raddr_i (ram_raddr),
    .rdata_o (ram_q)
  );

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    case (state_q)
      S_MUL1: begin
        mac_a = wc_q;
        mac_b = hc_q;
      end
      S_MUL2: begin
        mac_a = mac_p[MW-1:0];
        mac_b = dc_q;
      end
      S_HEAD: begin
        mac_a = zs_full[MW-1:0];
        mac_b = hc_q;
        mac_c = ys_full[MW-1:0];
      end
      S_SEC1: begin
        mac_a = mac_p[MW-1:0];
        mac_b = wc_q;
        mac_c = xs_full[MW-1:0];
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  voxbox_mac #(
    .W (MW)
  ) u_mac (
    .clk_i (clk_i),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .p_o   (mac_p)
  );

  // boundary columns take the next variant, low and high masks trim the segment
  always_comb begin
    alt  = (edges_q == 2'd2) ? 16'd0 : ram_q;
    bnd  = 16'd0;
    if (xb_q == bminx_q[25:4]) begin
      bnd = bnd | (16'd1 << bminx_q[3:0]);
    end
    if (xb_q == bmaxx_q[25:4]) begin
      bnd = bnd | (16'd1 << bmaxx_q[3:0]);
    end
    lo_m = 16'hffff << cx_q[3:0];
    hi_m = 16'hffff >> (4'd15 - end_q[3:0]);
  end

  always_comb begin
    nbit = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask_q[i]) begin
        nbit = 4'(i);
      end
    end
  end

  assign sel = {xb_q, nbit};

  always_comb begin
    state_d = state_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    over_d  = over_q;
    valid_d = valid_q;
    lim_d   = lim_q;
    cnt_d   = cnt_q;
    stat_d  = stat_q;
    wc_d    = wc_q;
    hc_d    = hc_q;
    dc_d    = dc_q;
    sec_d   = sec_q;
    end_d   = end_q;
    xb_d    = xb_q;
    edges_d = edges_q;
    mraw_d  = mraw_q;
    mask_d  = mask_q;
    ov_d    = ov_q && !m_axis_tready_i;
    okind_d = okind_q;
    olast_d = olast_q;
    ofin_d  = ofin_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    oz_d    = oz_q;
    oslot_d = oslot_q;
    ocnt_d  = ocnt_q;
    ostat_d = ostat_q;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_op)
            voxbox_pkg::OP_SET_SLOT: begin
              if (32'(in_slot) < VN) begin
                valid_d[in_slot[VW-1:0]] = in_pres;
              end
            end
            voxbox_pkg::OP_START: begin
              cx_d   = {1'b0, bminx_q};
              cy_d   = bminy_q;
              cz_d   = bminz_q;
              over_d = 1'b0;
            end
            voxbox_pkg::OP_PAGE: begin
              cnt_d  = 6'd0;
              lim_d  = lim_sat;
              stat_d = voxbox_pkg::ST_OK;
              if (in_limit == 6'd0) begin
                ov_d    = 1'b1;
                okind_d = voxbox_pkg::KIND_CLOSE;
                olast_d = 1'b1;
                ofin_d  = over_q;
                ox_d    = Bias;
                oy_d    = Bias;
                oz_d    = Bias;
                oslot_d = '0;
                ocnt_d  = '0;
                ostat_d = voxbox_pkg::ST_ZERO_LIMIT;
              end else begin
                state_d = S_CHK;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CHK: begin
        wc_d = wclip;
        hc_d = hclip;
        dc_d = dclip;
        if (over_q) begin
          state_d = S_HEAD;
        end else if (inverted) begin
          over_d  = 1'b1;
          state_d = S_HEAD;
        end else begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        state_d = S_MUL2;
      end
      S_MUL2: begin
        if (mac_p > PW'(MAX_SLOTS)) begin
          stat_d  = voxbox_pkg::ST_TOO_MANY;
          state_d = S_CLOSE;
        end else begin
          state_d = S_MUL3;
        end
      end
      S_MUL3: begin
        if (mac_p > PW'(MAX_SLOTS)) begin
          stat_d  = voxbox_pkg::ST_TOO_MANY;
          state_d = S_CLOSE;
        end else begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (over_q || (cnt_q >= lim_q)) begin
          state_d = S_CLOSE;
        end else if (cx_q > {1'b0, bmaxx_q}) begin
          cx_d = {1'b0, bminx_q};
          if (cy_q == bmaxy_q) begin
            cy_d = bminy_q;
            if (cz_q == bmaxz_q) begin
              over_d = 1'b1;
            end else begin
              cz_d = cz_q + 26'd1;
            end
          end else begin
            cy_d = cy_q + 26'd1;
          end
        end else begin
          state_d = S_SEC1;
        end
      end
      S_SEC1: begin
        state_d = S_SEC2;
      end
      S_SEC2: begin
        sec_d   = mac_p[MW-1:0];
        end_d   = endv;
        xb_d    = cx_q[25:4];
        edges_d = edges;
        if (sec_ok) begin
          state_d = S_RD1;
        end else begin
          cx_d    = {1'b0, endv} + 27'd1;
          state_d = S_HEAD;
        end
      end
      S_RD1: begin
        mraw_d  = ram_q;
        state_d = S_RD2;
      end
      S_RD2: begin
        mask_d  = ((mraw_q & ~bnd) | (alt & bnd)) & lo_m & hi_m;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (mask_q == 16'd0) begin
          cx_d    = {1'b0, end_q} + 27'd1;
          state_d = S_HEAD;
        end else if (cnt_q >= lim_q) begin
          state_d = S_CLOSE;
        end else if (out_free) begin
          ov_d    = 1'b1;
          okind_d = voxbox_pkg::KIND_HIT;
          olast_d = 1'b0;
          ofin_d  = 1'b0;
          ox_d    = sel;
          oy_d    = cy_q;
          oz_d    = cz_q;
          oslot_d = 6'(sec_q);
          ocnt_d  = '0;
          ostat_d = voxbox_pkg::ST_OK;
          mask_d  = mask_q & (mask_q - 16'd1);
          cnt_d   = cnt_q + 6'd1;
          cx_d    = {1'b0, sel} + 27'd1;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = voxbox_pkg::KIND_CLOSE;
          olast_d = 1'b1;
          ofin_d  = over_q;
          ox_d    = Bias;
          oy_d    = Bias;
          oz_d    = Bias;
          oslot_d = '0;
          ocnt_d  = cnt_q;
          ostat_d = stat_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bminx_q <= Bias;
      bminy_q <= Bias;
      bminz_q <= Bias;
      bmaxx_q <= Bias;
      bmaxy_q <= Bias;
      bmaxz_q <= Bias;
      cx_q    <= {1'b0, Bias};
      cy_q    <= Bias;
      cz_q    <= Bias;
      over_q  <= 1'b1;
      valid_q <= '0;
      lim_q   <= '0;
      cnt_q   <= '0;
      stat_q  <= voxbox_pkg::ST_OK;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      cz_q    <= cz_d;
      over_q  <= over_d;
      valid_q <= valid_d;
      lim_q   <= lim_d;
      cnt_q   <= cnt_d;
      stat_q  <= stat_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          3'd0: bminx_q <= cfg_data_i ^ Bias;
          3'd1: bminy_q <= cfg_data_i ^ Bias;
          3'd2: bminz_q <= cfg_data_i ^ Bias;
          3'd3: bmaxx_q <= cfg_data_i ^ Bias;
          3'd4: bmaxy_q <= cfg_data_i ^ Bias;
          3'd5: bmaxz_q <= cfg_data_i ^ Bias;
          default: bminx_q <= bminx_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wc_q    <= wc_d;
    hc_q    <= hc_d;
    dc_q    <= dc_d;
    sec_q   <= sec_d;
    end_q   <= end_d;
    xb_q    <= xb_d;
    edges_q <= edges_d;
    mraw_q  <= mraw_d;
    mask_q  <= mask_d;
    okind_q <= okind_d;
    olast_q <= olast_d;
    ofin_q  <= ofin_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    oz_q    <= oz_d;
    oslot_q <= oslot_d;
    ocnt_q  <= ocnt_d;
    ostat_q <= ostat_d;
  end

  // coordinates leave in two's complement
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {3'b000, ostat_q, ofin_q, ocnt_q, oslot_q,
                            oz_q ^ Bias, oy_q ^ Bias, ox_q ^ Bias};

  `VBOS_ASSERT(a_hit_not_last,
    (m_axis_tvalid_o && (m_axis_tuser_o[0] == voxbox_pkg::KIND_HIT)) |-> !m_axis_tlast_o,
    "hit record flagged as last")
  `VBOS_ASSERT(a_cnt_in_limit, (state_q != S_IDLE) |-> (cnt_q <= lim_q),
    "record count beyond page limit")
  `VBOS_NEVER(a_ram_wr_busy, ram_we && (state_q != S_IDLE),
    "mask write while a page is in progress")
  `VBOS_ASSERT(a_emit_counts,
    (state_q == S_EMIT && mask_q != 16'd0 && cnt_q < lim_q && out_free) |=>
      (cnt_q == $past(cnt_q) + 6'd1),
    "emitted hit not counted")

endmodule
